// ===== design/j3_2_track_message_decode_macros.svh =====
// Assertion macros for the J3.2 track message decoder.
// Needs i_clk and i_rst_n in the scope of the module that uses them.
`ifndef J3_2_TRACK_MESSAGE_DECODE_MACROS_SVH
`define J3_2_TRACK_MESSAGE_DECODE_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define J3TMD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define J3TMD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/j3tmd_pkg.sv =====
// Shared types and constants of the J3.2 track message decoder.
// No dependencies; used by the angle unit and the top level.
`timescale 1ns / 1ps
`default_nettype none

package j3tmd_pkg;

    // One input word: the five message words as they leave the receiver.
    typedef struct packed {
        logic [31:0] initial_word0;
        logic [5:0]  initial_word1_low;
        logic [31:0] ext_word0;
        logic [31:0] ext_word1;
        logic [5:0]  ext_word2_low;
    } t_in_word;

    // One output word: the decoded message.
    typedef struct packed {
        logic [7:0]  message_type;
        logic [18:0] track_number;
        logic [7:0]  status_flags;
        logic [19:0] course_speed;
        logic [1:0]  lat_hemisphere;
        logic [6:0]  lat_degrees;
        logic [5:0]  lat_minutes;
        logic [15:0] lat_millisec;
        logic [1:0]  lon_hemisphere;
        logic [7:0]  lon_degrees;
        logic [5:0]  lon_minutes;
        logic [15:0] lon_millisec;
    } t_out_word;

    // Hemisphere codes.
    localparam logic [1:0] HEMI_POS  = 2'd0;   // north or east
    localparam logic [1:0] HEMI_NEG  = 2'd1;   // south or west
    localparam logic [1:0] HEMI_NONE = 2'd2;   // no statement

    // Position code widths; the scale is all ones below the top bit.
    localparam int unsigned LAT_CODE_W = 21;
    localparam int unsigned LON_CODE_W = 22;
    localparam int unsigned LAT_SPAN   = 90;
    localparam int unsigned LON_SPAN   = 180;
    localparam int unsigned LAT_DEG_W  = 7;
    localparam int unsigned LON_DEG_W  = 8;
    localparam int unsigned MIN_W      = 6;
    localparam int unsigned MSEC_W     = 16;

    localparam int unsigned MS_PER_DEG  = 3600000;
    localparam int unsigned MS_PER_MIN  = 60000;
    localparam int unsigned MIN_PER_DEG = 60;

    // Register stages through the angle units.
    localparam int unsigned ANG_STAGES = 10;

endpackage

`default_nettype wire

// ===== design/j3tmd_angle.sv =====
// Pipelined conversion of one position code into hemisphere, degrees,
// minutes and milliseconds. Depends on j3tmd_pkg; stage enables come from the top.
`timescale 1ns / 1ps
`default_nettype none

module j3tmd_angle #(
    parameter int unsigned CODE_W = j3tmd_pkg::LAT_CODE_W,
    parameter int unsigned SPAN   = j3tmd_pkg::LAT_SPAN,
    parameter int unsigned DEG_W  = j3tmd_pkg::LAT_DEG_W
) (
    input  wire logic                            i_clk,
    input  wire logic [j3tmd_pkg::ANG_STAGES-1:0] i_en,
    input  wire logic [CODE_W-1:0]               i_code,
    output logic [1:0]                           o_hemi,
    output logic [DEG_W-1:0]                     o_degrees,
    output logic [j3tmd_pkg::MIN_W-1:0]          o_minutes,
    output logic [j3tmd_pkg::MSEC_W-1:0]         o_millisec
);
    import j3tmd_pkg::*;

    // The scale is 2^SB - 1, so division by it folds the high part of the
    // product back onto the low part. Two folds and one correction suffice
    // while the folded width stays within twice SB.
    localparam int unsigned SB    = CODE_W - 1;
    localparam int unsigned K_MS  = SPAN * MS_PER_DEG;
    localparam int unsigned KW    = $clog2(K_MS + 1);
    localparam int unsigned PW    = SB + KW;
    localparam int unsigned RW    = KW + 1;
    localparam int unsigned R1W   = SB + 1;
    localparam int unsigned TM_W  = $clog2(SPAN * MIN_PER_DEG + 1);
    localparam int unsigned MW    = KW + 31;
    localparam int unsigned DW    = TM_W + 15;
    localparam int unsigned DIF_W = 17;
    localparam int unsigned REM_W = 7;

    // Reciprocals: floor(2^46 / 60000) and floor(2^20 / 60). Both estimates
    // fall short of the true quotient by at most one.
    localparam logic [30:0] RECIP_MIN    = 31'd1172812402;
    localparam int unsigned RECIP_MIN_SH = 46;
    localparam logic [14:0] RECIP_DEG    = 15'd17476;
    localparam int unsigned RECIP_DEG_SH = 20;

    localparam logic [KW-1:0] K_VAL = KW'(K_MS);
    localparam logic [SB-1:0] SCALE = '1;

    logic [1:0]        r_hemi [ANG_STAGES];
    logic [SB-1:0]     r0_code;
    logic [PW-1:0]     r1_prod;
    logic [KW-1:0]     r2_q0;
    logic [RW-1:0]     r2_r0;
    logic [KW-1:0]     r3_q;
    logic [R1W-1:0]    r3_r1;
    logic [KW-1:0]     r4_tot;
    logic [KW-1:0]     r5_tot;
    logic [TM_W-1:0]   r5_test;
    logic [KW-1:0]     r6_tot;
    logic [KW-1:0]     r6_sub;
    logic [TM_W-1:0]   r6_test;
    logic [TM_W-1:0]   r7_tmin;
    logic [MSEC_W-1:0] r7_ms;
    logic [TM_W-1:0]   r8_tmin;
    logic [DEG_W-1:0]  r8_dest;
    logic [MSEC_W-1:0] r8_ms;
    logic [DEG_W-1:0]  r9_deg;
    logic [MIN_W-1:0]  r9_min;
    logic [MSEC_W-1:0] r9_ms;

    logic [1:0]        w_hemi0;
    logic [RW-SB-1:0]  w_q1;
    logic [MW-1:0]     w_pmin;
    logic [KW-1:0]     w_dfull;
    logic [DIF_W-1:0]  w_diff;
    logic [DW-1:0]     w_pdeg;
    logic [TM_W-1:0]   w_rfull;
    logic [REM_W-1:0]  w_rem;

    // Top bit clear: positive half. Top bit set with zero below: no
    // statement, and the zero code then yields zero fields by itself.
    always_comb begin
        if (!i_code[SB]) begin
            w_hemi0 = HEMI_POS;
        end else if (i_code[SB-1:0] == '0) begin
            w_hemi0 = HEMI_NONE;
        end else begin
            w_hemi0 = HEMI_NEG;
        end
    end

    assign w_q1    = r2_r0[RW-1:SB];
    assign w_pmin  = MW'(r4_tot) * MW'(RECIP_MIN);
    assign w_dfull = r6_tot - r6_sub;
    assign w_diff  = w_dfull[DIF_W-1:0];
    assign w_pdeg  = DW'(r7_tmin) * DW'(RECIP_DEG);
    assign w_rfull = r8_tmin - TM_W'(r8_dest) * TM_W'(MIN_PER_DEG);
    assign w_rem   = w_rfull[REM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_hemi[0] <= w_hemi0;
            r0_code   <= i_code[SB-1:0];
        end
        for (int k = 1; k < ANG_STAGES; k++) begin
            if (i_en[k]) begin
                r_hemi[k] <= r_hemi[k-1];
            end
        end
        // Product code * span * ms per degree.
        if (i_en[1]) begin
            r1_prod <= PW'(r0_code) * PW'(K_VAL);
        end
        // First fold.
        if (i_en[2]) begin
            r2_q0 <= r1_prod[PW-1:SB];
            r2_r0 <= RW'(r1_prod[SB-1:0]) + RW'(r1_prod[PW-1:SB]);
        end
        // Second fold.
        if (i_en[3]) begin
            r3_q  <= r2_q0 + KW'(w_q1);
            r3_r1 <= R1W'(r2_r0[SB-1:0]) + R1W'(w_q1);
        end
        // Remainder below twice the scale: one correction.
        if (i_en[4]) begin
            r4_tot <= r3_q + KW'(r3_r1 >= R1W'(SCALE));
        end
        // Estimate of whole minutes.
        if (i_en[5]) begin
            r5_tot  <= r4_tot;
            r5_test <= w_pmin[RECIP_MIN_SH +: TM_W];
        end
        if (i_en[6]) begin
            r6_tot  <= r5_tot;
            r6_test <= r5_test;
            r6_sub  <= KW'(r5_test) * KW'(MS_PER_MIN);
        end
        // Correct the minute estimate and keep the millisecond remainder.
        if (i_en[7]) begin
            if (w_diff >= DIF_W'(MS_PER_MIN)) begin
                r7_tmin <= r6_test + TM_W'(1);
                r7_ms   <= MSEC_W'(w_diff - DIF_W'(MS_PER_MIN));
            end else begin
                r7_tmin <= r6_test;
                r7_ms   <= MSEC_W'(w_diff);
            end
        end
        // Estimate of whole degrees.
        if (i_en[8]) begin
            r8_tmin <= r7_tmin;
            r8_ms   <= r7_ms;
            r8_dest <= w_pdeg[RECIP_DEG_SH +: DEG_W];
        end
        if (i_en[9]) begin
            r9_ms <= r8_ms;
            if (w_rem >= REM_W'(MIN_PER_DEG)) begin
                r9_deg <= r8_dest + DEG_W'(1);
                r9_min <= MIN_W'(w_rem - REM_W'(MIN_PER_DEG));
            end else begin
                r9_deg <= r8_dest;
                r9_min <= MIN_W'(w_rem);
            end
        end
    end

    assign o_hemi     = r_hemi[ANG_STAGES-1];
    assign o_degrees  = r9_deg;
    assign o_minutes  = r9_min;
    assign o_millisec = r9_ms;

endmodule

`default_nettype wire

// ===== design/j3_2_track_message_decode.sv =====
// Top level of the J3.2 track message decoder: field unpacking, stage
// control and two angle units. Depends on j3tmd_pkg, j3tmd_angle and the macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "j3_2_track_message_decode_macros.svh"

// Channel   Direction  Handshake                Word
// input     in         i_in_valid / o_in_stall  i_in_word  (t_in_word)
// output    out        o_out_valid / i_out_stall o_out_word (t_out_word)
//
// One word is taken per clock cycle while o_in_stall is low; each word passes
// in order through the register stages and leaves from the last one.
// The ten register stages are those of the angle units: code multiply, two
// folds and a correction for the scale, then reciprocal steps for minutes and degrees.
// Reset (synchronous, active low) clears the stage valid bits only.
// A stall freezes only the occupied stages that cannot move on, so empty
// stages still fill and no word is dropped or repeated.

module j3_2_track_message_decode (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire j3tmd_pkg::t_in_word i_in_word,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output j3tmd_pkg::t_out_word     o_out_word
);
    import j3tmd_pkg::*;

    // Fields that need no arithmetic ride alongside the angle units.
    typedef struct packed {
        logic [7:0]  message_type;
        logic [18:0] track_number;
        logic [7:0]  status_flags;
        logic [19:0] course_speed;
    } t_side;

    logic [ANG_STAGES-1:0] r_vld;
    logic [ANG_STAGES-1:0] n_vld;
    logic [ANG_STAGES-1:0] w_en;
    t_side                 r_side [ANG_STAGES];
    t_side                 w_side0;
    logic [LAT_CODE_W-1:0] w_lat_code;
    logic [LON_CODE_W-1:0] w_lon_code;

    logic [1:0]            w_lat_hemi;
    logic [LAT_DEG_W-1:0]  w_lat_deg;
    logic [MIN_W-1:0]      w_lat_min;
    logic [MSEC_W-1:0]     w_lat_ms;
    logic [1:0]            w_lon_hemi;
    logic [LON_DEG_W-1:0]  w_lon_deg;
    logic [MIN_W-1:0]      w_lon_min;
    logic [MSEC_W-1:0]     w_lon_ms;

    // Unpack the message words. The label sits above the sublabel in the
    // message type; the track number joins both initial words; the flags
    // gather six bits of the initial word with disused and active from the
    // extension words.
    always_comb begin
        w_side0.message_type = {i_in_word.initial_word0[6:2], i_in_word.initial_word0[9:7]};
        w_side0.track_number = {i_in_word.initial_word1_low, i_in_word.initial_word0[31:19]};
        w_side0.status_flags = {i_in_word.ext_word1[17], i_in_word.ext_word0[25],
                                i_in_word.initial_word0[18:13]};
        w_side0.course_speed = {i_in_word.ext_word1[26:18], i_in_word.ext_word2_low,
                                i_in_word.ext_word1[31:27]};
    end

    assign w_lat_code = i_in_word.ext_word0[24:4];
    assign w_lon_code = {i_in_word.ext_word1[16:0], i_in_word.ext_word0[31:27]};

    // A stage may load when it is empty or when the stage after it loads.
    // The last stage loads when its word is taken or it holds none.
    always_comb begin
        w_en[ANG_STAGES-1] = !r_vld[ANG_STAGES-1] || !i_out_stall;
        for (int k = ANG_STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_comb begin
        n_vld = r_vld;
        if (w_en[0]) begin
            n_vld[0] = i_in_valid;
        end
        for (int k = 1; k < ANG_STAGES; k++) begin
            if (w_en[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_side[0] <= w_side0;
        end
        for (int k = 1; k < ANG_STAGES; k++) begin
            if (w_en[k]) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    j3tmd_angle #(
        .CODE_W (LAT_CODE_W),
        .SPAN   (LAT_SPAN),
        .DEG_W  (LAT_DEG_W)
    ) u_lat (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_code     (w_lat_code),
        .o_hemi     (w_lat_hemi),
        .o_degrees  (w_lat_deg),
        .o_minutes  (w_lat_min),
        .o_millisec (w_lat_ms)
    );

    j3tmd_angle #(
        .CODE_W (LON_CODE_W),
        .SPAN   (LON_SPAN),
        .DEG_W  (LON_DEG_W)
    ) u_lon (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_code     (w_lon_code),
        .o_hemi     (w_lon_hemi),
        .o_degrees  (w_lon_deg),
        .o_minutes  (w_lon_min),
        .o_millisec (w_lon_ms)
    );

    assign o_in_stall  = !w_en[0];
    assign o_out_valid = r_vld[ANG_STAGES-1];

    always_comb begin
        o_out_word.message_type   = r_side[ANG_STAGES-1].message_type;
        o_out_word.track_number   = r_side[ANG_STAGES-1].track_number;
        o_out_word.status_flags   = r_side[ANG_STAGES-1].status_flags;
        o_out_word.course_speed   = r_side[ANG_STAGES-1].course_speed;
        o_out_word.lat_hemisphere = w_lat_hemi;
        o_out_word.lat_degrees    = w_lat_deg;
        o_out_word.lat_minutes    = w_lat_min;
        o_out_word.lat_millisec   = w_lat_ms;
        o_out_word.lon_hemisphere = w_lon_hemi;
        o_out_word.lon_degrees    = w_lon_deg;
        o_out_word.lon_minutes    = w_lon_min;
        o_out_word.lon_millisec   = w_lon_ms;
    end

    // An occupied stage that could not move on still holds a word next cycle.
    `J3TMD_ASSERT_NEXT(a_stalled_stage_kept,
        |(r_vld & ~w_en),
        (r_vld & $past(r_vld & ~w_en)) == $past(r_vld & ~w_en),
        "stalled stage lost its word")
    // The input side is held off only while the first stage is occupied.
    `J3TMD_ASSERT_NOW(a_stall_needs_full_front, o_in_stall, r_vld[0],
        "input stalled with an empty first stage")
    // A latitude without statement carries zero fields.
    `J3TMD_ASSERT_NOW(a_lat_none_zero,
        o_out_valid && (o_out_word.lat_hemisphere == HEMI_NONE),
        (o_out_word.lat_degrees == '0) && (o_out_word.lat_minutes == '0)
            && (o_out_word.lat_millisec == '0),
        "latitude without statement has non-zero fields")
    // Minutes and milliseconds stay inside their ranges.
    `J3TMD_ASSERT_NOW(a_sub_degree_range, o_out_valid,
        (o_out_word.lat_minutes < MIN_W'(MIN_PER_DEG))
            && (o_out_word.lon_minutes < MIN_W'(MIN_PER_DEG))
            && (o_out_word.lat_millisec < MSEC_W'(MS_PER_MIN))
            && (o_out_word.lon_millisec < MSEC_W'(MS_PER_MIN)),
        "minutes or milliseconds out of range")
    // Degrees never pass the span.
    `J3TMD_ASSERT_NOW(a_degree_range, o_out_valid,
        (o_out_word.lat_degrees <= LAT_DEG_W'(LAT_SPAN))
            && (o_out_word.lon_degrees <= LON_DEG_W'(LON_SPAN)),
        "degrees beyond span")

endmodule

`default_nettype wire
